[sv/rlcwf_pkg.sv]
package rlcwf_pkg;

  // command codes
  localparam logic [3:0] OP_TICK     = 4'd0;
  localparam logic [3:0] OP_SET_HUE  = 4'd1;
  localparam logic [3:0] OP_SET_RGB  = 4'd2;
  localparam logic [3:0] OP_WARM     = 4'd3;
  localparam logic [3:0] OP_COOL     = 4'd4;
  localparam logic [3:0] OP_RAINBOW  = 4'd5;
  localparam logic [3:0] OP_ON       = 4'd6;
  localparam logic [3:0] OP_OFF      = 4'd7;
  localparam logic [3:0] OP_TOGGLE   = 4'd8;

  // fade phases, six and seven both mean stopped
  localparam logic [2:0] PH_RED_YEL  = 3'd0;
  localparam logic [2:0] PH_YEL_GRN  = 3'd1;
  localparam logic [2:0] PH_GRN_TEAL = 3'd2;
  localparam logic [2:0] PH_TEAL_BLU = 3'd3;
  localparam logic [2:0] PH_BLU_MAG  = 3'd4;
  localparam logic [2:0] PH_MAG_RED  = 3'd5;
  localparam logic [2:0] PH_STOPPED  = 3'd6;

  localparam logic [7:0] LEVEL_MAX   = 8'd255;
  localparam logic [7:0] WARM_BLUE   = 8'd126;
  localparam logic [8:0] HUE_LIMIT   = 9'd360;
  localparam int         SECTOR_DEG  = 60;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 32;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } levels_t;

  typedef struct packed {
    levels_t duty;
    logic    led_on;
    logic    fade_running;
  } result_t;

  typedef struct packed {
    levels_t levels;
    logic    valid;
  } hue_res_t;

endpackage

[sv/rlcwf_hue.sv]
module rlcwf_hue (
  input  logic [8:0]        hue,
  output rlcwf_pkg::hue_res_t hue_res
);
  import rlcwf_pkg::*;

  logic [2:0] sector;
  logic [8:0] base;
  logic [5:0] frac;
  logic [6:0] frac_up;
  logic [6:0] frac_dn;
  logic [7:0] ramp_up;
  logic [7:0] ramp_dn;

  // 255 * f / 60 is exactly 17 * f / 4
  function automatic logic [7:0] ramp(input logic [6:0] x);
    logic [9:0] prod;
    prod = 10'(x) * 10'd17;
    return prod[9:2];
  endfunction

  // sector select by compares against multiples of sixty
  always_comb begin
    if (hue < 9'(SECTOR_DEG)) begin
      sector = 3'd0;
      base   = 9'd0;
    end else if (hue < 9'(2 * SECTOR_DEG)) begin
      sector = 3'd1;
      base   = 9'(SECTOR_DEG);
    end else if (hue < 9'(3 * SECTOR_DEG)) begin
      sector = 3'd2;
      base   = 9'(2 * SECTOR_DEG);
    end else if (hue < 9'(4 * SECTOR_DEG)) begin
      sector = 3'd3;
      base   = 9'(3 * SECTOR_DEG);
    end else if (hue < 9'(5 * SECTOR_DEG)) begin
      sector = 3'd4;
      base   = 9'(4 * SECTOR_DEG);
    end else begin
      sector = 3'd5;
      base   = 9'(5 * SECTOR_DEG);
    end
  end

  assign frac    = 6'(hue - base);
  assign frac_up = {1'b0, frac};
  assign frac_dn = 7'(SECTOR_DEG) - frac_up;
  assign ramp_up = ramp(frac_up);
  assign ramp_dn = ramp(frac_dn);

  always_comb begin
    hue_res.valid = (hue < HUE_LIMIT);
    case (sector)
      3'd0:    hue_res.levels = '{red: LEVEL_MAX, green: ramp_up,   blue: 8'd0};
      3'd1:    hue_res.levels = '{red: ramp_dn,   green: LEVEL_MAX, blue: 8'd0};
      3'd2:    hue_res.levels = '{red: 8'd0,      green: LEVEL_MAX, blue: ramp_up};
      3'd3:    hue_res.levels = '{red: 8'd0,      green: ramp_dn,   blue: LEVEL_MAX};
      3'd4:    hue_res.levels = '{red: ramp_up,   green: 8'd0,      blue: LEVEL_MAX};
      default: hue_res.levels = '{red: LEVEL_MAX, green: 8'd0,      blue: ramp_dn};
    endcase
  end

endmodule

[sv/rlcwf_update.sv]
module rlcwf_update (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step_en,
  input  logic [3:0]           operation,
  input  logic [23:0]          rgb_value,
  input  rlcwf_pkg::hue_res_t  hue_res,
  output rlcwf_pkg::result_t   res_nxt
);
  import rlcwf_pkg::*;

  levels_t    lv_r, lv_nxt, fade_lv;
  logic [2:0] ph_r, ph_nxt, fade_ph;
  logic       on_r, on_nxt;
  logic       running;

  assign running = (ph_r < PH_STOPPED);

  // one fade step, phase moves on when the channel reaches its end
  always_comb begin
    fade_lv = lv_r;
    fade_ph = ph_r;
    case (ph_r)
      PH_RED_YEL: begin
        if (lv_r.green != LEVEL_MAX) fade_lv.green = lv_r.green + 8'd1;
        if (fade_lv.red == LEVEL_MAX && fade_lv.green == LEVEL_MAX) fade_ph = PH_YEL_GRN;
      end
      PH_YEL_GRN: begin
        if (lv_r.red != 8'd0) fade_lv.red = lv_r.red - 8'd1;
        if (fade_lv.red == 8'd0 && fade_lv.green == LEVEL_MAX) fade_ph = PH_GRN_TEAL;
      end
      PH_GRN_TEAL: begin
        if (lv_r.blue != LEVEL_MAX) fade_lv.blue = lv_r.blue + 8'd1;
        if (fade_lv.green == LEVEL_MAX && fade_lv.blue == LEVEL_MAX) fade_ph = PH_TEAL_BLU;
      end
      PH_TEAL_BLU: begin
        if (lv_r.green != 8'd0) fade_lv.green = lv_r.green - 8'd1;
        if (fade_lv.green == 8'd0 && fade_lv.blue == LEVEL_MAX) fade_ph = PH_BLU_MAG;
      end
      PH_BLU_MAG: begin
        if (lv_r.red != LEVEL_MAX) fade_lv.red = lv_r.red + 8'd1;
        if (fade_lv.red == LEVEL_MAX && fade_lv.blue == LEVEL_MAX) fade_ph = PH_MAG_RED;
      end
      PH_MAG_RED: begin
        if (lv_r.blue != 8'd0) fade_lv.blue = lv_r.blue - 8'd1;
        if (fade_lv.red == LEVEL_MAX && fade_lv.blue == 8'd0) fade_ph = PH_RED_YEL;
      end
      default: ;
    endcase
  end

  always_comb begin
    lv_nxt = lv_r;
    ph_nxt = ph_r;
    on_nxt = on_r;
    case (operation)
      OP_TICK: begin
        if (running) begin
          lv_nxt = fade_lv;
          ph_nxt = fade_ph;
          on_nxt = 1'b1;
        end
      end
      OP_SET_HUE: begin
        if (hue_res.valid) lv_nxt = hue_res.levels;
        ph_nxt = PH_STOPPED;
        on_nxt = 1'b1;
      end
      OP_SET_RGB: begin
        lv_nxt = levels_t'(rgb_value);
        ph_nxt = PH_STOPPED;
        on_nxt = 1'b1;
      end
      OP_WARM: begin
        lv_nxt = '{red: LEVEL_MAX, green: LEVEL_MAX, blue: WARM_BLUE};
        ph_nxt = PH_STOPPED;
        on_nxt = 1'b1;
      end
      OP_COOL: begin
        lv_nxt = '{red: LEVEL_MAX, green: LEVEL_MAX, blue: LEVEL_MAX};
        ph_nxt = PH_STOPPED;
        on_nxt = 1'b1;
      end
      OP_RAINBOW: begin
        if (running) begin
          ph_nxt = PH_STOPPED;
        end else begin
          lv_nxt = '{red: LEVEL_MAX, green: 8'd0, blue: 8'd0};
          ph_nxt = PH_RED_YEL;
          on_nxt = 1'b1;
        end
      end
      OP_ON: on_nxt = 1'b1;
      OP_OFF: begin
        ph_nxt = PH_STOPPED;
        on_nxt = 1'b0;
      end
      OP_TOGGLE: begin
        if (on_r) begin
          ph_nxt = PH_STOPPED;
          on_nxt = 1'b0;
        end else begin
          on_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    res_nxt.duty         = on_nxt ? lv_nxt : '0;
    res_nxt.led_on       = on_nxt;
    res_nxt.fade_running = (ph_nxt < PH_STOPPED);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lv_r <= '0;
      ph_r <= PH_STOPPED;
      on_r <= 1'b0;
    end else if (step_en) begin
      lv_r <= lv_nxt;
      ph_r <= ph_nxt;
      on_r <= on_nxt;
    end
  end

endmodule

[sv/rgb_led_colour_wheel_fader_core.sv]
// channel   direction  tdata fields (lsb first)                         width
// in_*      slave      operation[3:0] hue[12:4] rgb_value[36:13] pad    40
// out_*     master     red[7:0] green[15:8] blue[23:16] on[24] fade[25] 32
//
// one transaction per cycle sustained while the output is not stalled
// an input register feeds the state update, whose result lands in the output register
// the led state advances when a command moves from the input register to the output
// rst_n is synchronous: levels zero, fade stopped, led off, both stages empty
// a stalled output holds its result; the input register keeps taking a
// transaction while the output can move on in the same cycle
module rgb_led_colour_wheel_fader_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // operation, hue, rgb_value, zero pad
  input  logic [rlcwf_pkg::IN_DATA_W-1:0]     in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // red_duty, green_duty, blue_duty, led_is_on, fade_running, zero pad
  output logic [rlcwf_pkg::OUT_DATA_W-1:0]    out_tdata
);
  import rlcwf_pkg::*;

  // input stage
  logic        s1_valid_r;
  logic [3:0]  s1_op_r;
  logic [8:0]  s1_hue_r;
  logic [23:0] s1_rgb_r;

  // output stage
  logic        out_valid_r;
  result_t     out_res_r;

  logic        out_adv;
  logic        step_en;
  hue_res_t    hue_res;
  result_t     res_nxt;

  // output register can take a new result when empty or being drained
  assign out_adv   = !out_valid_r || out_tready;
  assign step_en   = s1_valid_r && out_adv;
  assign in_tready = !s1_valid_r || out_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_op_r  <= in_tdata[3:0];
      s1_hue_r <= in_tdata[12:4];
      s1_rgb_r <= in_tdata[36:13];
    end
  end

  rlcwf_hue u_hue (
    .hue     (s1_hue_r),
    .hue_res (hue_res)
  );

  rlcwf_update u_update (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (step_en),
    .operation (s1_op_r),
    .rgb_value (s1_rgb_r),
    .hue_res   (hue_res),
    .res_nxt   (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_res_r.fade_running, out_res_r.led_on,
                       out_res_r.duty.blue, out_res_r.duty.green, out_res_r.duty.red};

endmodule

[sv/rlcwf_checker.sv]
module rlcwf_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic [rlcwf_pkg::IN_DATA_W-1:0]  in_tdata,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [rlcwf_pkg::OUT_DATA_W-1:0] out_tdata
);
  import rlcwf_pkg::*;

  logic in_seen;
  assign in_seen = in_tvalid && in_tready && (in_tdata[3:0] == OP_TICK || 1'b1);

  // a result needs a command taken earlier and registered in the input stage
  a_result_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_seen, 2))
    else $error("result without accepted command");

  // a running fade always drives the led
  a_fade_implies_on: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[25] |-> out_tdata[24])
    else $error("fade running while led off");

  // off means dark duty outputs and a zero pad
  a_off_is_dark: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[24] |-> out_tdata[23:0] == 24'd0 && out_tdata[31:26] == 6'd0)
    else $error("nonzero duty while led off");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed under stall");

endmodule

bind rgb_led_colour_wheel_fader_core rlcwf_checker u_rlcwf_checker (.*);
